// ===== src/tdi_pkg.sv =====
// Package for the TDI phase combiner: widths, CORDIC constants and arithmetic helpers.
// Used by tdi_cordic and tdi_phase_combiner; it depends on nothing else.
package tdi_pkg;

    localparam int PART_BITS    = 24;
    localparam int BIN_BITS     = 20;
    localparam int FRAC_BITS    = PART_BITS - 4;
    localparam int CPX_BITS     = 2 * PART_BITS;
    localparam int ANG_BITS     = 32;
    localparam int CORDIC_ITERS = 24;
    localparam int CORDIC_W     = 32;
    localparam int ITERS_PER_STAGE = 4;
    localparam int CORDIC_STAGES   = CORDIC_ITERS / ITERS_PER_STAGE;
    localparam int CORDIC_SHIFT    = 28 - FRAC_BITS;
    localparam int DIFF_DLY        = CORDIC_STAGES + 2;
    localparam int PIPE_LAT        = CORDIC_STAGES + 9;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 32'sd163008218;
    localparam logic signed [31:0] INV_SQRT3_Q30 = 32'sd619925131;

    typedef logic signed [PART_BITS-1:0] part_t;
    typedef struct packed {
        part_t re;
        part_t im;
    } cpx_t;

    typedef logic signed [CORDIC_W-1:0] cw_t;

    function automatic cw_t atan_turn(input int i);
        case (i)
            0:  atan_turn = 32'sd536870912;
            1:  atan_turn = 32'sd316933406;
            2:  atan_turn = 32'sd167458907;
            3:  atan_turn = 32'sd85004756;
            4:  atan_turn = 32'sd42667331;
            5:  atan_turn = 32'sd21354465;
            6:  atan_turn = 32'sd10679838;
            7:  atan_turn = 32'sd5340245;
            8:  atan_turn = 32'sd2670163;
            9:  atan_turn = 32'sd1335087;
            10: atan_turn = 32'sd667544;
            11: atan_turn = 32'sd333772;
            12: atan_turn = 32'sd166886;
            13: atan_turn = 32'sd83443;
            14: atan_turn = 32'sd41722;
            15: atan_turn = 32'sd20861;
            16: atan_turn = 32'sd10430;
            17: atan_turn = 32'sd5215;
            18: atan_turn = 32'sd2608;
            19: atan_turn = 32'sd1304;
            20: atan_turn = 32'sd652;
            21: atan_turn = 32'sd326;
            22: atan_turn = 32'sd163;
            23: atan_turn = 32'sd81;
            default: atan_turn = '0;
        endcase
    endfunction

    function automatic part_t sat48(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = (48'sd1 <<< (PART_BITS - 1)) - 48'sd1;
        lo = -hi - 48'sd1;
        if (v > hi)
            sat48 = hi[PART_BITS-1:0];
        else if (v < lo)
            sat48 = lo[PART_BITS-1:0];
        else
            sat48 = v[PART_BITS-1:0];
    endfunction

endpackage

// ===== src/tdi_cordic.sv =====
// Pipelined CORDIC that turns an angle in turns into exp(-j*2*pi*angle) at FRAC_BITS.
// Depends on tdi_pkg; stalls with the enable of the surrounding pipeline.
module tdi_cordic
    import tdi_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [ANG_BITS-1:0] angle,
    output cpx_t                phasor
);

    cw_t        x_reg [CORDIC_STAGES+1];
    cw_t        y_reg [CORDIC_STAGES+1];
    cw_t        z_reg [CORDIC_STAGES+1];
    logic [1:0] q_reg [CORDIC_STAGES+1];
    cpx_t       phasor_reg;

    logic [1:0]          q_in;
    logic [ANG_BITS-1:0] r_in;

    cw_t x_next [CORDIC_STAGES];
    cw_t y_next [CORDIC_STAGES];
    cw_t z_next [CORDIC_STAGES];

    assign q_in = 2'((angle + 32'h2000_0000) >> 30);
    assign r_in = angle - {q_in, 30'd0};

    always_comb
    begin
        cw_t xx;
        cw_t yy;
        cw_t zz;
        cw_t dx;
        cw_t dy;
        for (int s = 0; s < CORDIC_STAGES; s++)
        begin
            xx = x_reg[s];
            yy = y_reg[s];
            zz = z_reg[s];
            for (int k = 0; k < ITERS_PER_STAGE; k++)
            begin
                dx = yy >>> (s * ITERS_PER_STAGE + k);
                dy = xx >>> (s * ITERS_PER_STAGE + k);
                if (!zz[CORDIC_W-1])
                begin
                    xx = xx - dx;
                    yy = yy + dy;
                    zz = zz - atan_turn(s * ITERS_PER_STAGE + k);
                end
                else
                begin
                    xx = xx + dx;
                    yy = yy - dy;
                    zz = zz + atan_turn(s * ITERS_PER_STAGE + k);
                end
            end
            x_next[s] = xx;
            y_next[s] = yy;
            z_next[s] = zz;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CORDIC_X0;
            y_reg[0] <= '0;
            z_reg[0] <= cw_t'(r_in);
            q_reg[0] <= q_in;
            for (int s = 0; s < CORDIC_STAGES; s++)
            begin
                x_reg[s+1] <= x_next[s];
                y_reg[s+1] <= y_next[s];
                z_reg[s+1] <= z_next[s];
                q_reg[s+1] <= q_reg[s];
            end
        end
    end

    cw_t c_sel;
    cw_t s_sel;
    cw_t c_rnd;
    cw_t s_rnd;

    always_comb
    begin
        case (q_reg[CORDIC_STAGES])
            2'd0:
            begin
                c_sel = x_reg[CORDIC_STAGES];
                s_sel = y_reg[CORDIC_STAGES];
            end
            2'd1:
            begin
                c_sel = -y_reg[CORDIC_STAGES];
                s_sel = x_reg[CORDIC_STAGES];
            end
            2'd2:
            begin
                c_sel = -x_reg[CORDIC_STAGES];
                s_sel = -y_reg[CORDIC_STAGES];
            end
            default:
            begin
                c_sel = y_reg[CORDIC_STAGES];
                s_sel = -x_reg[CORDIC_STAGES];
            end
        endcase
        c_rnd = (c_sel + (cw_t'(1) <<< (CORDIC_SHIFT - 1))) >>> CORDIC_SHIFT;
        s_rnd = (s_sel + (cw_t'(1) <<< (CORDIC_SHIFT - 1))) >>> CORDIC_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            phasor_reg.re <= c_rnd[PART_BITS-1:0];
            phasor_reg.im <= part_t'(-s_rnd);
        end
    end

    assign phasor = phasor_reg;

endmodule

// ===== src/tdi_phase_combiner.sv =====
// Top level of the first-generation TDI Michelson combiner with A, E and T channels.
// Depends on tdi_pkg and tdi_cordic.
// Throughput: one bin per cycle whenever the pipeline advances.
// The whole pipeline advances when the output register is free or being emptied.
// Reset clears angle_step and all valid bits; payload registers are not reset.
module tdi_phase_combiner
    import tdi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bin_index[19:0], link_12, link_21, link_13, link_31, link_23, link_32, zero pad to 312
    input  logic [311:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // chan_x[47:0], chan_y, chan_z, chan_a, chan_e, chan_t
    output logic [287:0] m_axis_tdata
);

    logic [31:0]  angle_step_reg;
    logic         en;
    logic [PIPE_LAT-1:0] vld_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            angle_step_reg <= '0;
        else if (cfg_valid)
            angle_step_reg <= cfg_data;
    end

    assign en = !vld_reg[PIPE_LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_axis_tvalid};
    end

    // Stage 1: angle product and link differences.
    logic [31:0] theta_reg;
    cpx_t        lk [6];

    for (genvar i = 0; i < 6; i++)
    begin : g_unpack
        assign lk[i] = s_axis_tdata[BIN_BITS + CPX_BITS*i +: CPX_BITS];
    end

    // Differences kept with one extra bit in separate wide registers.
    logic signed [PART_BITS:0] dre_reg [6];
    logic signed [PART_BITS:0] dim_reg [6];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            theta_reg <= 32'(s_axis_tdata[BIN_BITS-1:0] * angle_step_reg);
            // lk: 0=L12 1=L21 2=L13 3=L31 4=L23 5=L32
            // X: d3=L12-L13 d2=L21-L31 ; d1=-d3 ; d0=-d2
            dre_reg[0] <= {lk[0].re[PART_BITS-1], lk[0].re} - {lk[2].re[PART_BITS-1], lk[2].re};
            dim_reg[0] <= {lk[0].im[PART_BITS-1], lk[0].im} - {lk[2].im[PART_BITS-1], lk[2].im};
            dre_reg[1] <= {lk[1].re[PART_BITS-1], lk[1].re} - {lk[3].re[PART_BITS-1], lk[3].re};
            dim_reg[1] <= {lk[1].im[PART_BITS-1], lk[1].im} - {lk[3].im[PART_BITS-1], lk[3].im};
            // Y: d3=L23-L21 d2=L32-L12
            dre_reg[2] <= {lk[4].re[PART_BITS-1], lk[4].re} - {lk[1].re[PART_BITS-1], lk[1].re};
            dim_reg[2] <= {lk[4].im[PART_BITS-1], lk[4].im} - {lk[1].im[PART_BITS-1], lk[1].im};
            dre_reg[3] <= {lk[5].re[PART_BITS-1], lk[5].re} - {lk[0].re[PART_BITS-1], lk[0].re};
            dim_reg[3] <= {lk[5].im[PART_BITS-1], lk[5].im} - {lk[0].im[PART_BITS-1], lk[0].im};
            // Z: d3=L31-L32 d2=L13-L23
            dre_reg[4] <= {lk[3].re[PART_BITS-1], lk[3].re} - {lk[5].re[PART_BITS-1], lk[5].re};
            dim_reg[4] <= {lk[3].im[PART_BITS-1], lk[3].im} - {lk[5].im[PART_BITS-1], lk[5].im};
            dre_reg[5] <= {lk[2].re[PART_BITS-1], lk[2].re} - {lk[4].re[PART_BITS-1], lk[4].re};
            dim_reg[5] <= {lk[2].im[PART_BITS-1], lk[2].im} - {lk[4].im[PART_BITS-1], lk[4].im};
        end
    end

    // Stage 2: multiples of the angle.
    logic [31:0] ang_reg [3];
    logic signed [PART_BITS:0] d2re_reg [6];
    logic signed [PART_BITS:0] d2im_reg [6];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg[0] <= theta_reg;
            ang_reg[1] <= {theta_reg[30:0], 1'b0};
            ang_reg[2] <= {theta_reg[30:0], 1'b0} + theta_reg;
            for (int i = 0; i < 6; i++)
            begin
                d2re_reg[i] <= dre_reg[i];
                d2im_reg[i] <= dim_reg[i];
            end
        end
    end

    cpx_t ph [3];
    for (genvar k = 0; k < 3; k++)
    begin : g_cordic
        tdi_cordic u_cordic (
            .clk    (clk),
            .en     (en),
            .angle  (ang_reg[k]),
            .phasor (ph[k])
        );
    end

    // Differences wait in the DIFF_DLY delay line alongside the CORDIC.
    logic signed [PART_BITS:0] dlre_reg [DIFF_DLY][6];
    logic signed [PART_BITS:0] dlim_reg [DIFF_DLY][6];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
            begin
                dlre_reg[0][i] <= d2re_reg[i];
                dlim_reg[0][i] <= d2im_reg[i];
            end
            for (int j = 1; j < DIFF_DLY; j++)
            begin
                dlre_reg[j] <= dlre_reg[j-1];
                dlim_reg[j] <= dlim_reg[j-1];
            end
        end
    end

    // Products: (d3-d1 style) channel = d3*(P3-P1) + d2*(P2-1); phasor difference widths.
    typedef logic signed [PART_BITS+1:0] pw_t;
    typedef logic signed [63:0] acc_t;
    logic signed [PART_BITS:0] ure [3];
    logic signed [PART_BITS:0] uim [3];
    logic signed [PART_BITS:0] vre [3];
    logic signed [PART_BITS:0] vim [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ure[c] = dlre_reg[DIFF_DLY-1][2*c];
            uim[c] = dlim_reg[DIFF_DLY-1][2*c];
            vre[c] = dlre_reg[DIFF_DLY-1][2*c+1];
            vim[c] = dlim_reg[DIFF_DLY-1][2*c+1];
        end
    end

    acc_t m_reg [3][8];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                m_reg[c][0] <= acc_t'(ure[c]) * acc_t'(pw_t'(ph[2].re) - pw_t'(ph[0].re));
                m_reg[c][1] <= acc_t'(uim[c]) * acc_t'(pw_t'(ph[2].im) - pw_t'(ph[0].im));
                m_reg[c][2] <= acc_t'(ure[c]) * acc_t'(pw_t'(ph[2].im) - pw_t'(ph[0].im));
                m_reg[c][3] <= acc_t'(uim[c]) * acc_t'(pw_t'(ph[2].re) - pw_t'(ph[0].re));
                m_reg[c][4] <= acc_t'(vre[c]) * acc_t'(pw_t'(ph[1].re) - (pw_t'(1) <<< FRAC_BITS));
                m_reg[c][5] <= acc_t'(vim[c]) * acc_t'(pw_t'(ph[1].im));
                m_reg[c][6] <= acc_t'(vre[c]) * acc_t'(pw_t'(ph[1].im));
                m_reg[c][7] <= acc_t'(vim[c]) * acc_t'(pw_t'(ph[1].re) - (pw_t'(1) <<< FRAC_BITS));
            end
        end
    end

    // Sum, round, saturate.
    cpx_t xyz_reg [3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                acc_t sr;
                acc_t si;
                sr = m_reg[c][0] - m_reg[c][1] + m_reg[c][4] - m_reg[c][5];
                si = m_reg[c][2] + m_reg[c][3] + m_reg[c][6] + m_reg[c][7];
                sr = (sr + (acc_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                si = (si + (acc_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                xyz_reg[c].re <= sat48(sr[47:0]);
                xyz_reg[c].im <= sat48(si[47:0]);
            end
        end
    end

    // A, E, T numerators.
    typedef logic signed [PART_BITS+3:0] nw_t;
    nw_t  na_re_reg, na_im_reg, nt_re_reg, nt_im_reg, ne_re_reg, ne_im_reg;
    cpx_t xyz2_reg [3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_re_reg <= nw_t'(2) * (nw_t'(2) * nw_t'(xyz_reg[0].re) - nw_t'(xyz_reg[1].re)
                         - nw_t'(xyz_reg[2].re)) + nw_t'(3);
            na_im_reg <= nw_t'(2) * (nw_t'(2) * nw_t'(xyz_reg[0].im) - nw_t'(xyz_reg[1].im)
                         - nw_t'(xyz_reg[2].im)) + nw_t'(3);
            nt_re_reg <= nw_t'(2) * (nw_t'(xyz_reg[0].re) + nw_t'(xyz_reg[1].re)
                         + nw_t'(xyz_reg[2].re)) + nw_t'(3);
            nt_im_reg <= nw_t'(2) * (nw_t'(xyz_reg[0].im) + nw_t'(xyz_reg[1].im)
                         + nw_t'(xyz_reg[2].im)) + nw_t'(3);
            ne_re_reg <= nw_t'(xyz_reg[2].re) - nw_t'(xyz_reg[1].re);
            ne_im_reg <= nw_t'(xyz_reg[2].im) - nw_t'(xyz_reg[1].im);
            xyz2_reg <= xyz_reg;
        end
    end

    // Division by 6 with floor through reciprocal multiply; E product.
    // floor(n/6) for |n| < 2^27: (n * 44739243) >>> 28 is exact after a correction.
    acc_t ep_re_reg, ep_im_reg;
    logic signed [63:0] pa_mul_re_reg, pa_mul_im_reg, pt_mul_re_reg, pt_mul_im_reg;
    nw_t  na_re2_reg, na_im2_reg, nt_re2_reg, nt_im2_reg;
    cpx_t xyz3_reg [3];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ep_re_reg <= acc_t'(ne_re_reg) * acc_t'(INV_SQRT3_Q30);
            ep_im_reg <= acc_t'(ne_im_reg) * acc_t'(INV_SQRT3_Q30);
            pa_mul_re_reg <= 64'(na_re_reg) * 64'sd44739243;
            pa_mul_im_reg <= 64'(na_im_reg) * 64'sd44739243;
            pt_mul_re_reg <= 64'(nt_re_reg) * 64'sd44739243;
            pt_mul_im_reg <= 64'(nt_im_reg) * 64'sd44739243;
            na_re2_reg <= na_re_reg;
            na_im2_reg <= na_im_reg;
            nt_re2_reg <= nt_re_reg;
            nt_im2_reg <= nt_im_reg;
            xyz3_reg <= xyz2_reg;
        end
    end

    function automatic logic signed [47:0] fix6(input nw_t n, input logic signed [63:0] p);
        logic signed [47:0] q;
        logic signed [47:0] r;
        q = 48'(p >>> 28);
        r = 48'(n) - q * 48'sd6;
        if (r < 0)
            q = q - 48'sd1;
        else if (r >= 48'sd6)
            q = q + 48'sd1;
        fix6 = q;
    endfunction

    logic [287:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_t er;
            acc_t ei;
            er = (ep_re_reg + (acc_t'(1) <<< 29)) >>> 30;
            ei = (ep_im_reg + (acc_t'(1) <<< 29)) >>> 30;
            out_reg[47:0]    <= {xyz3_reg[0].re, xyz3_reg[0].im};
            out_reg[95:48]   <= {xyz3_reg[1].re, xyz3_reg[1].im};
            out_reg[143:96]  <= {xyz3_reg[2].re, xyz3_reg[2].im};
            out_reg[191:144] <= {sat48(fix6(na_re2_reg, pa_mul_re_reg)),
                                 sat48(fix6(na_im2_reg, pa_mul_im_reg))};
            out_reg[239:192] <= {sat48(er[47:0]), sat48(ei[47:0])};
            out_reg[287:240] <= {sat48(fix6(nt_re2_reg, pt_mul_re_reg)),
                                 sat48(fix6(nt_im2_reg, pt_mul_im_reg))};
        end
    end

    assign m_axis_tdata = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!vld_reg[PIPE_LAT-1] || m_axis_tready))
        else $error("input ready does not follow pipeline enable");
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

endmodule

// ===== bench/tdi_phase_combiner_tb.sv =====
// Self-checking testbench for tdi_phase_combiner: random and directed bins checked against
// a fixed-point predictor of the X, Y, Z, A, E and T channels. Depends on tdi_pkg and the RTL.
module tdi_phase_combiner_tb
    import tdi_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        longint re;
        longint im;
    } wide_cpx_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 25;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [311:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [287:0] m_axis_tdata;

    logic [311:0] bin_feed[$];
    logic [287:0] channel_expect[$];
    logic [31:0]  step_now = '0;
    bit           bin_taken = 0;
    bit           quiet = 0;
    int           src_gap = 0;
    int           sink_gap = 0;
    int           sink_hold = 0;
    int           stall_count = 0;
    int           errors = 0;
    int           bins_sent = 0;
    int           bins_checked = 0;
    int           cfg_writes = 0;

    longint atan_q32[CORDIC_ITERS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    string chan_names[6] = '{"chan_x", "chan_y", "chan_z", "chan_a", "chan_e", "chan_t"};

    tdi_phase_combiner dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #4 clk = ~clk;

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip_part(longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    function automatic longint div3_nearest(longint n);
        longint num;
        num = 2 * n + 3;
        if (num >= 0)
            return num / 6;
        return -((-num + 5) / 6);
    endfunction

    function automatic wide_cpx_t to_wide(logic [47:0] p);
        wide_cpx_t c;
        c.re = longint'($signed(p[47:24]));
        c.im = longint'($signed(p[23:0]));
        return c;
    endfunction

    function automatic wide_cpx_t diff(wide_cpx_t a, wide_cpx_t b);
        wide_cpx_t r;
        r.re = a.re - b.re;
        r.im = a.im - b.im;
        return r;
    endfunction

    // Unit phasor exp(-j*2*pi*ang/2^32) from a quadrant-reduced CORDIC rotation.
    function automatic wide_cpx_t unit_phasor(logic [31:0] ang);
        logic [31:0] q;
        logic [31:0] resid;
        longint x, y, z, dx, dy, c, s;
        wide_cpx_t p;
        q = ((ang + 32'h2000_0000) >> 30) & 32'd3;
        resid = ang - (q << 30);
        z = longint'($signed(resid));
        x = 163008218;
        y = 0;
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_q32[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_q32[i];
            end
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        p.re = rnd_shift(c, 8);
        p.im = -rnd_shift(s, 8);
        return p;
    endfunction

    function automatic wide_cpx_t michelson(wide_cpx_t d3, wide_cpx_t d2, wide_cpx_t d1,
                                            wide_cpx_t d0, wide_cpx_t p1, wide_cpx_t p2,
                                            wide_cpx_t p3);
        longint re, im;
        wide_cpx_t r;
        re = d0.re <<< FRAC_BITS;
        im = d0.im <<< FRAC_BITS;
        re += d1.re * p1.re - d1.im * p1.im + d2.re * p2.re - d2.im * p2.im
            + d3.re * p3.re - d3.im * p3.im;
        im += d1.re * p1.im + d1.im * p1.re + d2.re * p2.im + d2.im * p2.re
            + d3.re * p3.im + d3.im * p3.re;
        r.re = clip_part(rnd_shift(re, FRAC_BITS));
        r.im = clip_part(rnd_shift(im, FRAC_BITS));
        return r;
    endfunction

    function automatic logic [47:0] to_packed(longint re, longint im);
        logic [23:0] r24, i24;
        r24 = re[23:0];
        i24 = im[23:0];
        return {r24, i24};
    endfunction

    function automatic logic [287:0] tdi_channels(logic [311:0] bin_req, logic [31:0] step);
        logic [31:0] theta;
        wide_cpx_t p1, p2, p3, l12, l21, l13, l31, l23, l32, x, y, z;
        longint ar, ai, er, ei, tr, ti;
        theta = bin_req[19:0] * step;
        p1 = unit_phasor(theta);
        p2 = unit_phasor(theta * 32'd2);
        p3 = unit_phasor(theta * 32'd3);
        l12 = to_wide(bin_req[67:20]);
        l21 = to_wide(bin_req[115:68]);
        l13 = to_wide(bin_req[163:116]);
        l31 = to_wide(bin_req[211:164]);
        l23 = to_wide(bin_req[259:212]);
        l32 = to_wide(bin_req[307:260]);
        x = michelson(diff(l12, l13), diff(l21, l31), diff(l13, l12), diff(l31, l21),
                      p1, p2, p3);
        y = michelson(diff(l23, l21), diff(l32, l12), diff(l21, l23), diff(l12, l32),
                      p1, p2, p3);
        z = michelson(diff(l31, l32), diff(l13, l23), diff(l32, l31), diff(l23, l13),
                      p1, p2, p3);
        ar = clip_part(div3_nearest(2 * x.re - y.re - z.re));
        ai = clip_part(div3_nearest(2 * x.im - y.im - z.im));
        er = clip_part(((z.re - y.re) * 619925131 + (longint'(1) << 29)) >>> 30);
        ei = clip_part(((z.im - y.im) * 619925131 + (longint'(1) << 29)) >>> 30);
        tr = clip_part(div3_nearest(x.re + y.re + z.re));
        ti = clip_part(div3_nearest(x.im + y.im + z.im));
        return {to_packed(tr, ti), to_packed(er, ei), to_packed(ar, ai),
                to_packed(z.re, z.im), to_packed(y.re, y.im), to_packed(x.re, x.im)};
    endfunction

    function automatic logic [23:0] rand_part();
        case ($urandom_range(0, 4))
            0: return 24'($urandom);
            1: return 24'($signed(18'($urandom)));
            2: return 24'($signed(12'($urandom)));
            3: return ($urandom_range(0, 1) != 0) ? 24'h7F_FFFF : 24'h80_0000;
            default: return 24'($signed(21'($urandom)));
        endcase
    endfunction

    function automatic logic [311:0] random_bin();
        logic [311:0] r;
        r = '0;
        r[19:0] = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(0, 15)) : 20'($urandom);
        for (int k = 0; k < 12; k++)
            r[20 + 24 * k +: 24] = rand_part();
        return r;
    endfunction

    function automatic logic [311:0] uniform_bin(logic [19:0] b, logic [23:0] part);
        logic [311:0] r;
        r = '0;
        r[19:0] = b;
        for (int k = 0; k < 12; k++)
            r[20 + 24 * k +: 24] = part;
        return r;
    endfunction

    // Input side: hand the next queued bin to the bus once the previous request is taken.
    always @(negedge clk)
    begin
        logic         nv;
        logic [311:0] nd;
        nv = s_axis_tvalid;
        nd = s_axis_tdata;
        if (bin_taken)
            nv = 1'b0;
        bin_taken = 0;
        if (rst_n && !nv)
        begin
            if (src_gap > 0)
                src_gap--;
            else if (bin_feed.size() > 0)
            begin
                nd = bin_feed[0];
                bin_feed.delete(0);
                nv = 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    src_gap = $urandom_range(1, 7);
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata <= nd;
    end

    always @(negedge clk)
    begin
        logic rdy;
        if (sink_hold > 0)
        begin
            sink_hold--;
            rdy = 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            rdy = 1'b0;
        end
        else
        begin
            rdy = 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0)
                sink_gap = $urandom_range(1, 7);
        end
        m_axis_tready <= rdy;
    end

    always @(posedge clk)
    begin
        logic [287:0] want;
        if (s_axis_tvalid && s_axis_tready)
        begin
            channel_expect.push_back(tdi_channels(s_axis_tdata, step_now));
            bin_taken = 1;
            bins_sent++;
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (channel_expect.size() == 0)
            begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = channel_expect[0];
                channel_expect.delete(0);
                for (int k = 0; k < 6; k++)
                    if (m_axis_tdata[48 * k +: 48] !== want[48 * k +: 48])
                    begin
                        $error("%s expected %h actual %h", chan_names[k],
                               want[48 * k +: 48], m_axis_tdata[48 * k +: 48]);
                        errors++;
                    end
                bins_checked++;
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic drain();
        wait (bin_feed.size() == 0 && !s_axis_tvalid && channel_expect.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_step(logic [31:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        step_now = v;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            bin_feed.push_back(random_bin());
    endtask

    task automatic queue_directed();
        bin_feed.push_back(uniform_bin(20'h0, 24'h00_0000));
        bin_feed.push_back(uniform_bin(20'hF_FFFF, 24'h7F_FFFF));
        bin_feed.push_back(uniform_bin(20'h1, 24'h80_0000));
        bin_feed.push_back(uniform_bin(20'h8_0000, 24'hFF_FFFF));
        for (int k = 0; k < 6; k++)
        begin
            logic [311:0] r;
            r = uniform_bin(20'(k + 2), 24'h00_0000);
            r[20 + 48 * k +: 48] = {24'h7F_FFFF, 24'h80_0000};
            bin_feed.push_back(r);
        end
    endtask

    initial
    begin
        logic [31:0] steps[5];
        steps = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h4000_0000, 32'h1234_5679};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_directed();
        drain();
        foreach (steps[i])
        begin
            write_step(steps[i]);
            queue_directed();
            if (i == 1)
            begin
                @(posedge clk);
                sink_hold = 150;
            end
            queue_random(45);
            drain();
        end
        for (int p = 0; p < 3; p++)
        begin
            write_step($urandom);
            queue_random(45);
            drain();
        end
        write_step(32'h0);
        queue_random(20);
        drain();
        quiet = 1;
        write_step($urandom);
        queue_random(40);
        drain();

        $display("Sent %0d bins and checked %0d against the channel predictor over %0d steps,",
                 bins_sent, bins_checked, cfg_writes + 1);
        $display("including zero and all-ones steps, saturating links and a long output stall.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
